// File: rtl/core/cie_pkg.sv
// Shared types and constants for the 16-bit instruction execute unit.
package cie_pkg;

    localparam int unsigned REG_COUNT  = 16;
    localparam int unsigned STEP_BYTES = 4;

    // opcodes
    localparam logic [7:0] OP_NOP   = 8'd0;
    localparam logic [7:0] OP_ADD   = 8'd1;
    localparam logic [7:0] OP_SUB   = 8'd2;
    localparam logic [7:0] OP_MUL   = 8'd3;
    localparam logic [7:0] OP_DIV   = 8'd4;
    localparam logic [7:0] OP_CMPGE = 8'd5;
    localparam logic [7:0] OP_RSHFT = 8'd6;
    localparam logic [7:0] OP_LSHFT = 8'd7;
    localparam logic [7:0] OP_AND   = 8'd8;
    localparam logic [7:0] OP_OR    = 8'd9;
    localparam logic [7:0] OP_XOR   = 8'd10;
    localparam logic [7:0] OP_LD    = 8'd11;
    localparam logic [7:0] OP_SETC  = 8'd12;
    localparam logic [7:0] OP_ST    = 8'd13;
    localparam logic [7:0] OP_BNZ   = 8'd14;
    localparam logic [7:0] OP_READY = 8'd15;

    // status codes
    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_BADOP  = 3'd1;
    localparam logic [2:0] STS_MEM    = 3'd2;
    localparam logic [2:0] STS_DIV0   = 3'd3;
    localparam logic [2:0] STS_BADREG = 3'd4;
    localparam logic [2:0] STS_HALT   = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_LD,
        S_ST,
        S_DONE
    } t_state;

    // divider start request
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_div_ctl;

endpackage

// File: rtl/core/cie_regfile.sv
// Register file: 16 x 16 synchronous RAM, two registered read ports, valid bits for reset.
module cie_regfile
    import cie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_rd0_addr,
    input  logic [3:0]  i_rd1_addr,
    input  logic        i_wr_en,
    input  logic [3:0]  i_wr_addr,
    input  logic [15:0] i_wr_data,
    output logic [15:0] o_rd0_data,
    output logic [15:0] o_rd1_data
);

    logic [15:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [15:0]          r_rd0;
    logic [15:0]          r_rd1;
    logic                 r_v0;
    logic                 r_v1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[i_rd0_addr];
        r_rd1 <= r_mem[i_rd1_addr];
        r_v0  <= r_vld[i_rd0_addr];
        r_v1  <= r_vld[i_rd1_addr];
    end

    assign o_rd0_data = r_v0 ? r_rd0 : 16'h0000;
    assign o_rd1_data = r_v1 ? r_rd1 : 16'h0000;

endmodule

// File: rtl/core/cie_dmem.sv
// Data memory: single-port-write word RAM with a clearing pass after reset.
module cie_dmem
    import cie_pkg::*;
#(
    parameter int unsigned DATA_WORDS = 4096,
    parameter int unsigned ADDR_W     = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [15:0]       i_wr_data,
    output logic [15:0]       o_rd_data,
    output logic              o_busy
);

    logic [15:0]       r_mem [DATA_WORDS];
    logic [15:0]       r_rd;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // clearing sweep, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DATA_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // write port: sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 16'h0000;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_clearing;

endmodule

// File: rtl/core/cie_div.sv
// Iterative 16-bit unsigned divider, one quotient bit a cycle.
module cie_div
    import cie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_ctl    i_ctl,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_dvs;
    logic [16:0] rem_sh;
    logic        fits;

    // restoring step; the remainder always stays below the divisor
    assign rem_sh = {r_rem, r_quo[15]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_ctl.dividend;
            r_dvs <= i_ctl.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(rem_sh - {1'b0, r_dvs}) : rem_sh[15:0];
            r_quo <= {r_quo[14:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/cpu16_instruction_execute_unit.sv
// Top level: sequencer for the 16-bit instruction execute unit.
// Steps: accept, execute and result for most instructions; LD and ST add a memory step,
// MUL adds two register file writes, DIV waits for the 16-step divider.
// Throughput: one instruction at a time; the next one is accepted once its result is handed to o_valid.
// Reset: registers and pointer read as zero at once; the data memory is swept to zero
// word by word after reset, with o_stall high meanwhile.
module cpu16_instruction_execute_unit
    import cie_pkg::*;
#(
    parameter int unsigned DATA_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_next_ip
);

    localparam int unsigned ADDR_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    t_state      r_state, n_state;
    logic [31:0] r_instr;
    logic [15:0] r_ip;
    logic [2:0]  r_res_status, n_res_status;
    logic [15:0] r_res_ip, n_res_ip;
    logic [31:0] r_prod;
    logic [ADDR_W-1:0] r_addr;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [15:0] r_out_ip;

    logic        accept;
    logic        out_free;
    logic [7:0]  op, fa, fb, fc;
    logic [7:0]  in_op;
    logic [15:0] x, y;
    logic [15:0] sum;
    logic        sum_ok;
    logic        bad_reg;
    logic [15:0] ip_step;

    logic [3:0]  rf_rd0_addr, rf_rd1_addr;
    logic        rf_wr_en;
    logic [3:0]  rf_wr_addr;
    logic [15:0] rf_wr_data;
    logic [15:0] rf_rd0_data, rf_rd1_data;
    logic        dm_rd_en, dm_wr_en, dm_busy;
    logic [15:0] dm_rd_data;
    t_div_ctl    div_ctl;
    logic        div_done;
    logic [15:0] div_quo;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign in_op = i_instruction_word[31:24];
    assign op    = r_instr[31:24];
    assign fa    = r_instr[23:16];
    assign fb    = r_instr[15:8];
    assign fc    = r_instr[7:0];
    assign x     = rf_rd0_data;
    assign y     = rf_rd1_data;
    assign sum   = x + y;
    assign sum_ok  = {1'b0, sum} < 17'(DATA_WORDS);
    assign ip_step = r_ip + 16'(STEP_BYTES);

    // register field checks
    assign bad_reg = ((fa[7:4] != 4'd0) && (op != OP_SETC) && (op != OP_READY))
                  || (((op <= OP_LD) || (op == OP_ST)) && (fb[7:4] != 4'd0))
                  || (((op <= OP_LD) || (op == OP_SETC) || (op == OP_ST))
                      && (fc[7:4] != 4'd0));

    // read addresses: ST reads b and c first, then a
    always_comb begin
        if (r_state == S_IDLE) begin
            rf_rd0_addr = (in_op == OP_ST) ? i_instruction_word[11:8]
                                           : i_instruction_word[19:16];
            rf_rd1_addr = (in_op == OP_ST) ? i_instruction_word[3:0]
                                           : i_instruction_word[11:8];
        end else begin
            rf_rd0_addr = fa[3:0];
            rf_rd1_addr = fb[3:0];
        end
    end

    cie_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd0_addr (rf_rd0_addr),
        .i_rd1_addr (rf_rd1_addr),
        .i_wr_en    (rf_wr_en),
        .i_wr_addr  (rf_wr_addr),
        .i_wr_data  (rf_wr_data),
        .o_rd0_data (rf_rd0_data),
        .o_rd1_data (rf_rd1_data)
    );

    cie_dmem #(
        .DATA_WORDS (DATA_WORDS),
        .ADDR_W     (ADDR_W)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (dm_rd_en),
        .i_rd_addr (sum[ADDR_W-1:0]),
        .i_wr_en   (dm_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (rf_rd0_data),
        .o_rd_data (dm_rd_data),
        .o_busy    (dm_busy)
    );

    cie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, register file, memory and divider control
    always_comb begin
        n_state          = r_state;
        n_res_status     = r_res_status;
        n_res_ip         = r_res_ip;
        rf_wr_en         = 1'b0;
        rf_wr_addr       = fc[3:0];
        rf_wr_data       = 16'h0000;
        dm_rd_en         = 1'b0;
        dm_wr_en         = 1'b0;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = x;
        div_ctl.divisor  = y;
        unique case (r_state)
            S_CLEAR: begin
                if (!dm_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state      = S_DONE;
                n_res_status = STS_OK;
                n_res_ip     = ip_step;
                if (bad_reg) begin
                    n_res_status = STS_BADREG;
                    n_res_ip     = r_ip;
                end else begin
                    unique case (op)
                        OP_NOP: begin
                        end
                        OP_ADD, OP_SUB, OP_CMPGE, OP_RSHFT, OP_LSHFT,
                        OP_AND, OP_OR, OP_XOR: begin
                            rf_wr_en = 1'b1;
                            case (op)
                                OP_ADD:   rf_wr_data = sum;
                                OP_SUB:   rf_wr_data = x - y;
                                OP_CMPGE: rf_wr_data = {15'd0, x >= y};
                                OP_RSHFT: rf_wr_data = (y[15:4] != 12'd0) ? 16'h0000
                                                                          : (x >> y[3:0]);
                                OP_LSHFT: rf_wr_data = (y[15:4] != 12'd0) ? 16'h0000
                                                                          : (x << y[3:0]);
                                OP_AND:   rf_wr_data = x & y;
                                OP_OR:    rf_wr_data = x | y;
                                default:  rf_wr_data = x ^ y;
                            endcase
                        end
                        OP_MUL: begin
                            n_state = S_MUL_LO;
                        end
                        OP_DIV: begin
                            if (y == 16'h0000) begin
                                n_res_status = STS_DIV0;
                                n_res_ip     = r_ip;
                            end else begin
                                div_ctl.start = 1'b1;
                                n_state       = S_DIV;
                            end
                        end
                        OP_LD: begin
                            if (sum_ok) begin
                                dm_rd_en = 1'b1;
                                n_state  = S_LD;
                            end else begin
                                n_res_status = STS_MEM;
                                n_res_ip     = r_ip;
                            end
                        end
                        OP_SETC: begin
                            rf_wr_en   = 1'b1;
                            rf_wr_data = {fa, fb};
                        end
                        OP_ST: begin
                            if (sum_ok) begin
                                n_state = S_ST;
                            end else begin
                                n_res_status = STS_MEM;
                                n_res_ip     = r_ip;
                            end
                        end
                        OP_BNZ: begin
                            if (x != 16'h0000) begin
                                n_res_ip = {fb, fc};
                            end
                        end
                        OP_READY: begin
                            n_res_status = STS_HALT;
                            n_res_ip     = 16'h0000;
                        end
                        default: begin
                            n_res_status = STS_BADOP;
                            n_res_ip     = r_ip;
                        end
                    endcase
                end
            end
            S_MUL_LO: begin
                rf_wr_en   = 1'b1;
                rf_wr_data = r_prod[15:0];
                n_state    = S_MUL_HI;
            end
            S_MUL_HI: begin
                rf_wr_en   = 1'b1;
                rf_wr_addr = fc[3:0] + 4'd1;
                rf_wr_data = r_prod[31:16];
                n_state    = S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    rf_wr_en   = 1'b1;
                    rf_wr_data = div_quo;
                    n_state    = S_DONE;
                end
            end
            S_LD: begin
                rf_wr_en   = 1'b1;
                rf_wr_data = dm_rd_data;
                n_state    = S_DONE;
            end
            S_ST: begin
                dm_wr_en = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // instruction latch, product, store address, pending result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_instr <= i_instruction_word;
        end
        if (r_state == S_EXEC) begin
            r_prod <= x * y;
            r_addr <= sum[ADDR_W-1:0];
        end
        r_res_status <= n_res_status;
        r_res_ip     <= n_res_ip;
    end

    // instruction pointer, updated when the result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip <= 16'h0000;
        end else if ((r_state == S_DONE) && out_free) begin
            r_ip <= r_res_ip;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_res_status;
            r_out_ip     <= r_res_ip;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_next_ip = r_out_ip;

    // checks
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_halt_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STS_HALT)) |-> (o_next_ip == 16'h0000))
        else $error("halt reported with non-zero pointer");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> (div_ctl.divisor != 16'h0000))
        else $error("divider started with zero divisor");

    a_no_write_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dm_busy |-> (!dm_wr_en && !dm_rd_en && o_stall))
        else $error("data memory access during clearing sweep");

endmodule

// File: tb/sv/tb_cpu16_instruction_execute_unit.sv
// Testbench for the 16-bit instruction execute unit: random and directed instructions.
`timescale 1ns / 1ps

module tb_cpu16_instruction_execute_unit;
    import cie_pkg::*;

    localparam int unsigned DATA_WORDS = 4096;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    // idling modes
    typedef enum int {
        MODE_SEND_IDLE,
        MODE_RECV_IDLE,
        MODE_NO_IDLE
    } t_idle_mode;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] next_ip;
    } t_exec_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instruction_word;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [15:0] o_next_ip;

    cpu16_instruction_execute_unit #(
        .DATA_WORDS(DATA_WORDS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_instruction_word (i_instruction_word),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_next_ip          (o_next_ip)
    );

    // shadow machine state
    logic [15:0] shadow_regs [REG_COUNT];
    logic [15:0] shadow_ip;
    logic [15:0] shadow_mem [DATA_WORDS];

    logic [31:0]  pending_instrs [$];
    t_exec_result expected_results [$];
    t_idle_mode   idle_mode;
    int           mismatch_count;
    int           watchdog_cycles;
    int           hold_off_cycles;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // predicted outcome of one instruction, updating the shadow state
    function automatic t_exec_result execute_instr(input logic [31:0] word);
        t_exec_result res;
        logic [7:0]  op, fa, fb, fc;
        logic [15:0] x, y, addr;
        logic [31:0] prod;
        logic [3:0]  rc;
        op = word[31:24];
        fa = word[23:16];
        fb = word[15:8];
        fc = word[7:0];
        res.status = STS_OK;
        if (fa >= REG_COUNT && op != OP_SETC && op != OP_READY)
            res.status = STS_BADREG;
        else if ((op <= OP_LD || op == OP_ST) && fb >= REG_COUNT)
            res.status = STS_BADREG;
        else if ((op <= OP_LD || op == OP_SETC || op == OP_ST) && fc >= REG_COUNT)
            res.status = STS_BADREG;
        else if (op > OP_READY)
            res.status = STS_BADOP;
        else if (op == OP_READY) begin
            shadow_ip = '0;
            res.status = STS_HALT;
        end else begin
            x = shadow_regs[fa[3:0]];
            y = shadow_regs[fb[3:0]];
            rc = fc[3:0];
            case (op)
                OP_NOP: ;
                OP_ADD:   shadow_regs[rc] = x + y;
                OP_SUB:   shadow_regs[rc] = x - y;
                OP_MUL: begin
                    prod = x * y;
                    shadow_regs[rc] = prod[15:0];
                    shadow_regs[rc + 4'd1] = prod[31:16];
                end
                OP_DIV: begin
                    if (y == 0) res.status = STS_DIV0;
                    else shadow_regs[rc] = x / y;
                end
                OP_CMPGE: shadow_regs[rc] = (x >= y) ? 16'd1 : 16'd0;
                OP_RSHFT: shadow_regs[rc] = (y >= 16) ? 16'd0 : x >> y[3:0];
                OP_LSHFT: shadow_regs[rc] = (y >= 16) ? 16'd0 : x << y[3:0];
                OP_AND:   shadow_regs[rc] = x & y;
                OP_OR:    shadow_regs[rc] = x | y;
                OP_XOR:   shadow_regs[rc] = x ^ y;
                OP_LD: begin
                    addr = x + y;
                    if (addr >= DATA_WORDS) res.status = STS_MEM;
                    else shadow_regs[rc] = shadow_mem[addr];
                end
                OP_SETC:  shadow_regs[rc] = {fa, fb};
                OP_ST: begin
                    addr = shadow_regs[fb[3:0]] + shadow_regs[rc];
                    if (addr >= DATA_WORDS) res.status = STS_MEM;
                    else shadow_mem[addr] = x;
                end
                OP_BNZ: begin
                    if (x != 0) begin
                        shadow_ip = {fb, fc};
                        res.status = STS_HALT; // marker, fixed below
                    end
                end
                default: ;
            endcase
            // taken branch skips the pointer step
            if (res.status == STS_HALT) res.status = STS_OK;
            else if (res.status == STS_OK) shadow_ip = shadow_ip + STEP_BYTES[15:0];
        end
        res.next_ip = shadow_ip;
        return res;
    endfunction

    // driver: one request at a time from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(execute_instr(i_instruction_word));
            end
            if (!i_valid || !o_stall) begin
                if (pending_instrs.size() > 0 &&
                    !(idle_mode == MODE_SEND_IDLE && $urandom_range(99) < 15) &&
                    !(idle_mode == MODE_RECV_IDLE && $urandom_range(99) < 78)) begin
                    i_valid <= 1'b1;
                    i_instruction_word <= pending_instrs.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall and monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            watchdog_cycles <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", o_status, 0);
                end else begin
                    t_exec_result want;
                    want = expected_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_next_ip !== want.next_ip)
                        report_mismatch("next_ip", o_next_ip, want.next_ip);
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) watchdog_cycles <= 0;
            else watchdog_cycles <= watchdog_cycles + 1;
            if (hold_off_cycles > 0) begin
                i_stall <= 1'b1;
                hold_off_cycles <= hold_off_cycles - 1;
            end else if (idle_mode == MODE_RECV_IDLE) i_stall <= ($urandom_range(99) < 15);
            else if (idle_mode == MODE_SEND_IDLE) i_stall <= ($urandom_range(99) < 78);
            else i_stall <= 1'b0;
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (watchdog_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] make_instr(input logic [7:0] op, input logic [7:0] fa,
                                               input logic [7:0] fb, input logic [7:0] fc);
        return {op, fa, fb, fc};
    endfunction

    // mostly valid register fields, sometimes any byte
    function automatic logic [7:0] rand_field();
        if ($urandom_range(19) == 0) return 8'($urandom);
        return 8'($urandom_range(15));
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [7:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) op = 8'($urandom_range(16, 255));
        else op = 8'($urandom_range(15));
        // setting constants often keeps addresses in range and values varied
        if (pick >= 4 && pick < 24)
            return make_instr(OP_SETC, 8'($urandom), 8'($urandom), rand_field());
        if (op == OP_SETC && $urandom_range(1))
            return make_instr(OP_SETC, 8'($urandom_range(15)), 8'($urandom), rand_field());
        if (op == OP_READY && $urandom_range(3) != 0) op = OP_ADD;
        return make_instr(op, rand_field(), rand_field(), rand_field());
    endfunction

    task automatic wait_drained();
        while (pending_instrs.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [7:0] op_code;
        mismatch_count = 0;
        hold_off_cycles = 0;
        idle_mode = MODE_SEND_IDLE;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_instruction_word = '0;
        foreach (shadow_regs[k]) shadow_regs[k] = '0;
        foreach (shadow_mem[k]) shadow_mem[k] = '0;
        shadow_ip = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and every special case
        pending_instrs.push_back(make_instr(OP_LD, 8'd0, 8'd0, 8'd1));      // cleared memory
        pending_instrs.push_back(make_instr(OP_SETC, 8'hFF, 8'hFF, 8'd2));
        pending_instrs.push_back(make_instr(OP_MUL, 8'd2, 8'd2, 8'd15));    // high half wraps
        pending_instrs.push_back(make_instr(OP_DIV, 8'd2, 8'd3, 8'd4));     // divide by zero
        pending_instrs.push_back(make_instr(OP_DIV, 8'd2, 8'd0, 8'd4));
        pending_instrs.push_back(make_instr(OP_SETC, 8'd0, 8'd16, 8'd5));
        pending_instrs.push_back(make_instr(OP_LSHFT, 8'd2, 8'd5, 8'd6));   // shift of 16
        pending_instrs.push_back(make_instr(OP_RSHFT, 8'd2, 8'd2, 8'd6));
        pending_instrs.push_back(make_instr(OP_LD, 8'd2, 8'd0, 8'd7));      // out of range
        pending_instrs.push_back(make_instr(OP_ST, 8'd2, 8'd5, 8'd2));      // wraps to 15
        pending_instrs.push_back(make_instr(OP_LD, 8'd5, 8'd2, 8'd8));
        pending_instrs.push_back(make_instr(OP_ST, 8'd2, 8'd2, 8'd0));
        pending_instrs.push_back(make_instr(8'd16, 8'd0, 8'd0, 8'd0));      // bad opcode
        pending_instrs.push_back(make_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF));   // bad register
        pending_instrs.push_back(make_instr(OP_SETC, 8'hFF, 8'd0, 8'd16));  // SETC dest check
        pending_instrs.push_back(make_instr(OP_LD, 8'd0, 8'd0, 8'hFF));     // LD dest check
        pending_instrs.push_back(make_instr(OP_ADD, 8'd0, 8'hF0, 8'd0));
        pending_instrs.push_back(make_instr(OP_BNZ, 8'd2, 8'hFF, 8'hFC));   // taken, near wrap
        pending_instrs.push_back(make_instr(OP_NOP, 8'd0, 8'd0, 8'd0));     // pointer wraps
        pending_instrs.push_back(make_instr(OP_BNZ, 8'd0, 8'h12, 8'h34));   // taken, r0 is non-zero
        pending_instrs.push_back(make_instr(OP_CMPGE, 8'd2, 8'd5, 8'd9));
        for (int k = OP_SUB; k <= OP_XOR; k++) begin
            op_code = 8'(k);
            pending_instrs.push_back(make_instr(op_code, 8'd2, 8'd5, 8'd10));
        end
        pending_instrs.push_back(make_instr(OP_READY, 8'hAA, 8'hBB, 8'hCC));
        wait_drained();

        // receiver holds off while requests keep coming
        idle_mode = MODE_NO_IDLE;
        hold_off_cycles = 300;
        repeat (40) pending_instrs.push_back(rand_instr());
        wait_drained();

        // random phases
        repeat (380) pending_instrs.push_back(rand_instr());
        idle_mode = MODE_SEND_IDLE;
        wait_drained();
        repeat (380) pending_instrs.push_back(rand_instr());
        idle_mode = MODE_RECV_IDLE;
        wait_drained();
        repeat (380) pending_instrs.push_back(rand_instr());
        idle_mode = MODE_NO_IDLE;
        wait_drained();

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
